// ----- rtl/core/ide_pkg.sv -----
// Shared types and constants for the indexed deque engine.
// Holds field widths, opcodes, payload structs and the controller/datapath
// command and status structs. No dependencies.
package ide_pkg;

  // Default sizing and fixed field widths.
  localparam int IDE_CAPACITY    = 64;
  localparam int IDE_VALUE_WIDTH = 32;
  localparam int IDE_OP_W        = 3;
  localparam int IDE_POS_W       = 7;
  localparam int IDE_VAL_W       = 32;

  // Operation codes; the one remaining code is treated as a no-op failure.
  typedef enum logic [IDE_OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6
  } opcode_t;

  // Operation class after decode.
  typedef enum logic [1:0] {
    K_NONE,
    K_PUT,
    K_TAKE,
    K_FIND
  } kind_t;

  // Read address source for the entry memory.
  typedef enum logic [1:0] {
    RD_SRC,
    RD_CUR,
    RD_FRONT,
    RD_BACK
  } rd_sel_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SHIFT,
    S_PLACE,
    S_FIND,
    S_RD_FRONT,
    S_RD_BACK,
    S_DONE
  } state_t;

  // Input transaction payload.
  typedef struct packed {
    logic [IDE_OP_W-1:0]         opcode;
    logic [IDE_POS_W-1:0]        position_in;
    logic signed [IDE_VAL_W-1:0] value_in;
  } ide_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic                        ok;
    logic [IDE_POS_W-1:0]        found_position;
    logic signed [IDE_VAL_W-1:0] front_value;
    logic signed [IDE_VAL_W-1:0] back_value;
    logic                        is_empty;
    logic [IDE_POS_W-1:0]        entry_count;
  } ide_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    shift_en;
    logic    place;
    logic    dec;
    logic    find_en;
    logic    cap_front;
    logic    out_load;
    rd_sel_t rd_sel;
  } ide_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  fail;
    logic  more;
    logic  pend;
    logic  out_free;
  } ide_stat_t;

endpackage

// ----- rtl/core/ide_if.sv -----
// Valid/ready channel interfaces for the indexed deque engine.
// Depends on ide_pkg for the payload structs.
interface ide_in_if import ide_pkg::*; ();
  logic    valid;
  logic    ready;
  ide_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ide_out_if import ide_pkg::*; ();
  logic     valid;
  logic     ready;
  ide_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ide_ctrl.sv -----
// Sequencing state machine for the indexed deque engine.
// Depends on ide_pkg for the state, command and status types.
module ide_ctrl import ide_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ide_stat_t stat,
  output ide_ctl_t  ctl
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = RD_BACK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.fail) begin
          state_next = S_RD_FRONT;
        end else begin
          unique case (stat.kind)
            K_PUT, K_TAKE: state_next = S_SHIFT;
            K_FIND:        state_next = S_FIND;
            default:       state_next = S_RD_FRONT;
          endcase
        end
      end
      S_SHIFT: begin
        ctl.shift_en = 1'b1;
        ctl.rd_sel   = RD_SRC;
        if (!(stat.more || stat.pend)) begin
          if (stat.kind == K_PUT) begin
            state_next = S_PLACE;
          end else begin
            ctl.dec    = 1'b1;
            state_next = S_RD_FRONT;
          end
        end
      end
      S_PLACE: begin
        ctl.place  = 1'b1;
        state_next = S_RD_FRONT;
      end
      S_FIND: begin
        ctl.find_en = 1'b1;
        ctl.rd_sel  = RD_CUR;
        if (!(stat.more || stat.pend)) begin
          state_next = S_RD_FRONT;
        end
      end
      S_RD_FRONT: begin
        ctl.rd_sel = RD_FRONT;
        state_next = S_RD_BACK;
      end
      S_RD_BACK: begin
        ctl.rd_sel    = RD_BACK;
        ctl.cap_front = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        ctl.rd_sel = RD_BACK;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ide_datapath.sv -----
// Entry memory, count, shift/search cursor and result register.
// Depends on ide_pkg; driven by ide_ctrl through command and status structs.
module ide_datapath import ide_pkg::*; #(
  parameter int CAPACITY    = IDE_CAPACITY,
  parameter int VALUE_WIDTH = IDE_VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  ide_in_t   in_data,
  input  ide_ctl_t  ctl,
  output ide_stat_t stat,
  input  logic      out_ready,
  output logic      out_valid,
  output ide_out_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > IDE_POS_W) ? CW : IDE_POS_W;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] word;
  logic [VALUE_WIDTH-1:0] front_word;
  logic [CW-1:0]          count;
  logic [CW-1:0]          pos_eff;
  logic [CW-1:0]          cur;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          found;
  kind_t                  kind;
  logic                   fail;
  logic                   pend;
  logic                   hit;

  logic                   full;
  logic                   empty;
  logic [PW-1:0]          pos_req;
  logic [PW-1:0]          cnt_ext;
  kind_t                  kind_d;
  logic                   fail_d;
  logic [CW-1:0]          pos_d;
  logic [CW-1:0]          cur_d;
  logic                   more;
  logic                   match;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   we;

  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_req = PW'(in_data.position_in);
  assign cnt_ext = PW'(count);
  assign match   = pend && !hit && (rdata == word);

  // Decode the incoming operation into a class, a failure flag and a position.
  always_comb begin
    unique case (in_data.opcode)
      OP_PUSH_FRONT: begin
        kind_d = K_PUT;
        fail_d = full;
        pos_d  = '0;
      end
      OP_PUSH_BACK: begin
        kind_d = K_PUT;
        fail_d = full;
        pos_d  = count;
      end
      OP_POP_FRONT: begin
        kind_d = K_TAKE;
        fail_d = empty;
        pos_d  = '0;
      end
      OP_POP_BACK: begin
        kind_d = K_TAKE;
        fail_d = empty;
        pos_d  = count - 1'b1;
      end
      OP_INSERT: begin
        kind_d = K_PUT;
        fail_d = full;
        pos_d  = (pos_req >= cnt_ext) ? count : CW'(in_data.position_in);
      end
      OP_REMOVE: begin
        kind_d = K_TAKE;
        fail_d = (pos_req >= cnt_ext);
        pos_d  = CW'(in_data.position_in);
      end
      OP_FIND: begin
        kind_d = K_FIND;
        fail_d = 1'b0;
        pos_d  = '0;
      end
      default: begin
        kind_d = K_NONE;
        fail_d = 1'b1;
        pos_d  = '0;
      end
    endcase
    // Inserts walk down from the end, removes walk up from the hole.
    unique case (kind_d)
      K_PUT:   cur_d = count;
      K_TAKE:  cur_d = pos_d;
      default: cur_d = '0;
    endcase
  end

  // Whether the cursor still has an entry to read.
  always_comb begin
    unique case (kind)
      K_PUT:   more = (cur > pos_eff);
      K_TAKE:  more = (({1'b0, cur} + 1'b1) < {1'b0, count});
      K_FIND:  more = (cur < count) && !hit;
      default: more = 1'b0;
    endcase
  end

  // Read address selection.
  always_comb begin
    unique case (ctl.rd_sel)
      RD_SRC:   raddr = (kind == K_PUT) ? AW'(cur - 1'b1) : AW'(cur + 1'b1);
      RD_CUR:   raddr = AW'(cur);
      RD_FRONT: raddr = '0;
      RD_BACK:  raddr = AW'(count - 1'b1);
      default:  raddr = '0;
    endcase
  end

  // Write port: moved entry during a shift, new word on placement.
  always_comb begin
    we    = ctl.shift_en && pend;
    waddr = AW'(idx);
    wdata = rdata;
    if (ctl.place) begin
      we    = 1'b1;
      waddr = AW'(pos_eff);
      wdata = word;
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control state: count, pipeline flags and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        pend <= 1'b0;
        hit  <= 1'b0;
      end
      if (ctl.shift_en || ctl.find_en) begin
        pend <= more;
      end
      if (ctl.find_en && match) begin
        hit <= 1'b1;
      end
      if (ctl.place) begin
        count <= count + 1'b1;
      end
      if (ctl.dec) begin
        count <= count - 1'b1;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation registers, cursor and result payload.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind    <= kind_d;
      fail    <= fail_d;
      pos_eff <= pos_d;
      word    <= VALUE_WIDTH'(in_data.value_in);
      cur     <= cur_d;
      found   <= (kind_d == K_FIND) ? count : '0;
    end
    if (ctl.shift_en && more) begin
      idx <= cur;
      cur <= (kind == K_PUT) ? cur - 1'b1 : cur + 1'b1;
    end
    if (ctl.find_en) begin
      if (more) begin
        idx <= cur;
        cur <= cur + 1'b1;
      end
      if (match) begin
        found <= idx;
      end
    end
    if (ctl.cap_front) begin
      front_word <= rdata;
    end
    if (ctl.out_load) begin
      out_data.ok             <= !fail;
      out_data.found_position <= IDE_POS_W'(found);
      out_data.front_value    <= empty ? '0 : IDE_VAL_W'(front_word);
      out_data.back_value     <= empty ? '0 : IDE_VAL_W'(rdata);
      out_data.is_empty       <= empty;
      out_data.entry_count    <= IDE_POS_W'(count);
    end
  end

  assign stat.kind     = kind;
  assign stat.fail     = fail;
  assign stat.more     = more;
  assign stat.pend     = pend;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ----- rtl/core/indexed_deque_engine.sv -----
// Top level of the indexed deque engine: a bounded list of signed words.
// Depends on ide_pkg, ide_if, ide_ctrl and ide_datapath.
//
//   Channel | Role  | Payload
//   --------+-------+---------------------------------------------------------
//   req     | sink  | opcode, position_in, value_in
//   rsp     | source| ok, found_position, front_value, back_value, is_empty,
//           |       | entry_count
//
// One transaction at a time: a push or insert first shifts entries from the end to
// open the slot, a pop or remove shifts them over the hole, a find reads entries
// until a match or the end, and a failed or unused operation moves none; req is
// ready again once the result is loaded. The memory's single read and write port
// move or compare one entry per cycle. Reset clears the count, the flags, the result
// valid and the state. A stalled rsp holds the result while the next req is worked on.
module indexed_deque_engine import ide_pkg::*; #(
  parameter int CAPACITY    = IDE_CAPACITY,
  parameter int VALUE_WIDTH = IDE_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  ide_in_if.sink     req,
  ide_out_if.source  rsp
);

  ide_ctl_t  ctl;
  ide_stat_t stat;

  // Sequencer.
  ide_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Storage and result path.
  ide_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (req.data),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_data  (rsp.data)
  );

endmodule
